/* rtl/core/tom_pkg.sv */
// Shared types, register codes and tanh table builder for the tanh overdrive block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tom_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int LP_W       = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DRIVE_GAIN = 3'd0;
	localparam cfg_idx_t REG_NORM_GAIN  = 3'd1;
	localparam cfg_idx_t REG_TONE_COEF  = 3'd2;
	localparam cfg_idx_t REG_WET_GAIN   = 3'd3;
	localparam cfg_idx_t REG_DRY_GAIN   = 3'd4;

	localparam logic [15:0] DRIVE_RESET = 16'd4096;
	localparam logic [14:0] NORM_RESET  = 15'd16395;
	localparam logic [15:0] TONE_RESET  = 16'd44571;
	localparam logic [16:0] WET_RESET   = 17'd32768;
	localparam logic [16:0] DRY_RESET   = 17'd32768;

	localparam logic [16:0] TANH_ONE = 17'd65536;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_ROMA,
		ST_ROMB,
		ST_INTERP,
		ST_TH,
		ST_NORM,
		ST_SHAPE,
		ST_TONE,
		ST_LP,
		ST_WET,
		ST_MIX
	} state_t;

	// Shift-subtract divide, used only while building the table.
	function automatic logic [63:0] tom_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry k is tanh(4k/seg) in Q0.16, built from exp(-8/seg) in Q0.32.
	function automatic logic [15:0] tom_tanh_entry(input int seg, input int k);
		logic signed [63:0] sum;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		sum  = '0;
		term = 64'd1 << 32;
		for (int n = 0; n < 24; n++) begin
			if ((n & 1) != 0) sum = sum - $signed(term);
			else sum = sum + $signed(term);
			term = tom_udiv(term * 64'd8, 64'(seg) * 64'(n + 1));
		end
		if (sum < 0) sum = '0;
		r = sum;
		if (r >= (64'd1 << 32)) r = (64'd1 << 32) - 64'd1;
		e = 64'd1 << 32;
		for (int j = 0; j < k; j++) begin
			e = (e * r + (64'd1 << 31)) >> 32;
		end
		num = ((64'd1 << 32) - e) << 16;
		den = (64'd1 << 32) + e;
		q   = tom_udiv(num + (den >> 1), den);
		return q[15:0];
	endfunction

endpackage

/* rtl/core/tom_if.sv */
// Valid/ready channels for stereo sample words in and mixed words out.
// No dependencies.
`timescale 1ns / 1ps

interface tom_in_if #(parameter int SAMPLE_WIDTH = 16) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_left;
	logic signed [SAMPLE_WIDTH-1:0] sample_right;

	modport source(output valid, output sample_left, output sample_right, input ready);
	modport sink(input valid, input sample_left, input sample_right, output ready);
endinterface

interface tom_out_if #(parameter int SAMPLE_WIDTH = 16) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_left;
	logic signed [SAMPLE_WIDTH-1:0] out_right;

	modport source(output valid, output out_left, output out_right, input ready);
	modport sink(input valid, input out_left, input out_right, output ready);
endinterface

/* rtl/core/tanh_overdrive_tone_mix.sv */
// Stereo tanh overdrive with one-pole tone filter and wet/dry mix.
// Depends on tom_pkg and the tom_in_if / tom_out_if channels.
// The output word becomes valid when the right channel's mix step loads it; a new word
// is accepted only back in idle. Both channels share one 18 x max(SAMPLE_WIDTH+12, 26)
// multiplier, 11 sequencer steps per channel. A held output word stalls the last step.
// Reset: filter states clear to zero, registers load their defaults, output is empty.
`timescale 1ns / 1ps

module tanh_overdrive_tone_mix #(
	parameter int TANH_SEGMENTS = 64,
	parameter int SAMPLE_WIDTH  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  tom_pkg::cfg_idx_t                 wr_index,
	input  logic [tom_pkg::CFG_DATA_W-1:0]    wr_data,
	tom_in_if.sink                            samples,
	tom_out_if.source                         mixed
);
	import tom_pkg::*;

	localparam int FB  = SAMPLE_WIDTH + 11;
	localparam int BW  = ((FB > 25) ? FB : 25) + 1;
	localparam int PW  = 18 + BW;
	localparam int IW  = $clog2(TANH_SEGMENTS) + 5;
	localparam int RA  = $clog2(TANH_SEGMENTS + 1);
	localparam int MW  = 43;
	localparam int LSH = 24 - SAMPLE_WIDTH;
	localparam int RSH = 39 - SAMPLE_WIDTH;

	localparam logic signed [MW-1:0] OUT_HI = MW'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [MW-1:0] OUT_LO = -OUT_HI - MW'(1);
	localparam logic signed [26:0] LP_HI = 27'((1 <<< (LP_W - 1)) - 1);
	localparam logic signed [26:0] LP_LO = -LP_HI - 27'(1);

	logic [15:0] rom [TANH_SEGMENTS+1];

	for (genvar k = 0; k <= TANH_SEGMENTS; k++) begin : g_rom
		localparam logic [15:0] ENTRY = tom_tanh_entry(TANH_SEGMENTS, k);
		assign rom[k] = ENTRY;
	end

	state_t state_q, state_d;
	logic   ch_q;
	logic   out_valid_q;
	logic   out_load;

	logic [15:0] drive_q;
	logic [14:0] norm_q;
	logic [15:0] tone_q;
	logic [16:0] wet_q;
	logic [16:0] dry_q;
	logic signed [LP_W-1:0] lp_q [2];

	logic signed [SAMPLE_WIDTH-1:0] xl_q, xr_q;
	logic signed [SAMPLE_WIDTH-1:0] res_left_q;
	logic signed [SAMPLE_WIDTH-1:0] out_left_q, out_right_q;
	logic signed [PW-1:0]           prod_q;
	logic [RA-1:0]                  idx_q;
	logic                           sat_q;
	logic [FB-1:0]                  frac_q;
	logic [15:0]                    a_q, b_q;
	logic [16:0]                    th_q;
	logic signed [LP_W-1:0]         shaped_q;
	logic signed [MW-1:0]           acc_q;

	logic signed [SAMPLE_WIDTH-1:0] x_cur;
	logic                           x_neg;
	logic [SAMPLE_WIDTH-1:0]        mag;
	logic [BW-1:0]                  mag_seg;
	logic signed [LP_W-1:0]         lp_cur;
	logic [IW-1:0]                  idx_full;
	logic                           idx_sat;
	logic [RA-1:0]                  rom_addr;
	logic [15:0]                    rom_data;
	logic [15:0]                    diff_ab;
	logic signed [PW-1:0]           rnd_sum;
	logic [16:0]                    th_next;
	logic signed [PW-1:0]           sh_sum;
	logic [17:0]                    sh;
	logic signed [26:0]             shaped_w;
	logic signed [LP_W-1:0]         shaped_next;
	logic signed [24:0]             lp_diff;
	logic signed [26:0]             lp_sum;
	logic signed [LP_W-1:0]         lp_next;
	logic signed [MW-1:0]           mix_sum;
	logic signed [MW-1:0]           mix_rnd;
	logic signed [SAMPLE_WIDTH-1:0] mix_out;

	logic                           mul_en;
	logic signed [17:0]             mul_a;
	logic signed [BW-1:0]           mul_b;
	logic signed [PW-1:0]           mul_p;

	assign mul_p = mul_a * mul_b;

	// datapath helpers
	assign x_cur    = ch_q ? xr_q : xl_q;
	assign x_neg    = x_cur[SAMPLE_WIDTH-1];
	assign mag      = x_neg ? SAMPLE_WIDTH'(-x_cur) : SAMPLE_WIDTH'(x_cur);
	assign mag_seg  = BW'(mag) * BW'(TANH_SEGMENTS);
	assign lp_cur   = lp_q[ch_q];
	assign idx_full = prod_q[FB +: IW];
	assign idx_sat  = idx_full >= IW'(TANH_SEGMENTS);
	assign rom_data = rom[rom_addr];
	assign diff_ab  = (b_q >= a_q) ? (b_q - a_q) : 16'd0;

	assign rnd_sum = prod_q + (PW'(1) <<< (FB - 1));
	assign th_next = sat_q ? TANH_ONE : (17'(a_q) + rnd_sum[FB +: 17]);

	assign sh_sum   = prod_q + PW'(8192);
	assign sh       = sh_sum[14 +: 18];
	assign shaped_w = x_neg ? -$signed({3'b000, sh, 6'b000000})
	                        : $signed({3'b000, sh, 6'b000000});
	always_comb begin
		if (shaped_w > LP_HI) shaped_next = LP_W'(LP_HI);
		else if (shaped_w < LP_LO) shaped_next = LP_W'(LP_LO);
		else shaped_next = LP_W'(shaped_w);
	end

	assign lp_diff = 25'(shaped_q) - 25'(lp_cur);
	assign lp_sum  = 27'(lp_cur) + 27'((prod_q + (PW'(1) <<< 15)) >>> 16);
	always_comb begin
		if (lp_sum > LP_HI) lp_next = LP_W'(LP_HI);
		else if (lp_sum < LP_LO) lp_next = LP_W'(LP_LO);
		else lp_next = LP_W'(lp_sum);
	end

	assign mix_sum = acc_q + MW'(prod_q);
	assign mix_rnd = (mix_sum + (MW'(1) <<< (RSH - 1))) >>> RSH;
	always_comb begin
		if (mix_rnd > OUT_HI) mix_out = SAMPLE_WIDTH'(OUT_HI);
		else if (mix_rnd < OUT_LO) mix_out = SAMPLE_WIDTH'(OUT_LO);
		else mix_out = SAMPLE_WIDTH'(mix_rnd);
	end

	assign out_load = (state_q == ST_MIX) && ch_q && (!out_valid_q || mixed.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (samples.valid) state_d = ST_POS;
			ST_POS:    state_d = ST_ROMA;
			ST_ROMA:   state_d = ST_ROMB;
			ST_ROMB:   state_d = ST_INTERP;
			ST_INTERP: state_d = ST_TH;
			ST_TH:     state_d = ST_NORM;
			ST_NORM:   state_d = ST_SHAPE;
			ST_SHAPE:  state_d = ST_TONE;
			ST_TONE:   state_d = ST_LP;
			ST_LP:     state_d = ST_WET;
			ST_WET:    state_d = ST_MIX;
			ST_MIX: begin
				if (!ch_q) state_d = ST_POS;
				else if (out_load) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands, table address, ready
	always_comb begin
		samples.ready = 1'b0;
		mul_en        = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		rom_addr      = idx_q + RA'(1);
		unique case (state_q)
			ST_IDLE: samples.ready = 1'b1;
			ST_POS: begin
				mul_en = 1'b1;
				mul_a  = 18'(drive_q);
				mul_b  = mag_seg;
			end
			ST_ROMA:   rom_addr = idx_sat ? '0 : idx_full[RA-1:0];
			ST_ROMB:   rom_addr = idx_q + RA'(1);
			ST_INTERP: begin
				mul_en = 1'b1;
				mul_a  = 18'(diff_ab);
				mul_b  = BW'(frac_q);
			end
			ST_TH: ;
			ST_NORM: begin
				mul_en = 1'b1;
				mul_a  = 18'(th_q);
				mul_b  = BW'(norm_q);
			end
			ST_SHAPE: ;
			ST_TONE: begin
				mul_en = 1'b1;
				mul_a  = 18'(tone_q);
				mul_b  = BW'(lp_diff);
			end
			ST_LP: begin
				mul_en = 1'b1;
				mul_a  = 18'(dry_q);
				mul_b  = BW'(x_cur);
			end
			ST_WET: begin
				mul_en = 1'b1;
				mul_a  = 18'(wet_q);
				mul_b  = BW'(lp_cur);
			end
			ST_MIX: ;
			default: ;
		endcase
	end

	// control, registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= DRIVE_RESET;
			norm_q      <= NORM_RESET;
			tone_q      <= TONE_RESET;
			wet_q       <= WET_RESET;
			dry_q       <= DRY_RESET;
			lp_q[0]     <= '0;
			lp_q[1]     <= '0;
		end else begin
			state_q <= state_d;
			if (samples.valid && samples.ready) ch_q <= 1'b0;
			else if (state_q == ST_MIX && !ch_q) ch_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (mixed.ready) out_valid_q <= 1'b0;
			if (state_q == ST_LP) lp_q[ch_q] <= lp_next;
			if (wr_en) begin
				unique case (wr_index)
					REG_DRIVE_GAIN: drive_q <= wr_data[15:0];
					REG_NORM_GAIN:  norm_q  <= wr_data[14:0];
					REG_TONE_COEF:  tone_q  <= wr_data[15:0];
					REG_WET_GAIN:   wet_q   <= wr_data[16:0];
					REG_DRY_GAIN:   dry_q   <= wr_data[16:0];
					default: ;
				endcase
			end
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			xl_q <= samples.sample_left;
			xr_q <= samples.sample_right;
		end
		if (mul_en) prod_q <= mul_p;
		case (state_q)
			ST_ROMA: begin
				idx_q  <= rom_addr;
				sat_q  <= idx_sat;
				frac_q <= prod_q[FB-1:0];
				a_q    <= rom_data;
			end
			ST_ROMB:  b_q      <= rom_data;
			ST_TH:    th_q     <= th_next;
			ST_SHAPE: shaped_q <= shaped_next;
			ST_WET:   acc_q    <= MW'(prod_q) <<< LSH;
			ST_MIX: begin
				if (!ch_q) res_left_q <= mix_out;
				if (out_load) begin
					out_left_q  <= res_left_q;
					out_right_q <= mix_out;
				end
			end
			default: ;
		endcase
	end

	assign mixed.valid     = out_valid_q;
	assign mixed.out_left  = out_left_q;
	assign mixed.out_right = out_right_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> state_q == ST_POS && !ch_q)
		else $error("accepted word did not start the left channel");

	a_load_after_right: assert property (@(posedge clk) disable iff (!arst_n)
		mixed.valid && !$past(mixed.valid) |-> $past(state_q) == ST_MIX && $past(ch_q))
		else $error("output word loaded outside the right channel mix step");

	a_tanh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHAPE |-> th_q <= TANH_ONE)
		else $error("interpolated tanh magnitude above one");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the stereo tanh overdrive, tone filter and mix block.
// Needs tom_pkg, the tom_in_if / tom_out_if channels and the block itself.
// Streams frames through its own bit-exact model under random valid/ready idling.

module testbench;
	import tom_pkg::*;

	localparam int SW               = 16;
	localparam int TANH_SEGS        = 64;
	localparam int FRAC_BITS        = SW + 11;
	localparam int RANDOM_PHASES    = 6;
	localparam int FRAMES_PER_PHASE = 205;
	localparam int HOLD_CYCLES      = 400;
	localparam int STALL_LIMIT      = 4000;
	localparam int TAIL_CYCLES      = 50;

	localparam longint LP_HI  = 64'sd8388607;
	localparam longint LP_LO  = -64'sd8388608;
	localparam longint OUT_HI = 64'sd32767;
	localparam longint OUT_LO = -64'sd32768;

	localparam cfg_idx_t REG_SPARE_5 = 3'd5;
	localparam cfg_idx_t REG_SPARE_6 = 3'd6;
	localparam cfg_idx_t REG_SPARE_7 = 3'd7;

	typedef enum logic [1:0] {ROW_END, ROW_WRITE, ROW_FRAME} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_idx_t    ix;
		logic [16:0] val;
		logic [15:0] l;
		logic [15:0] r;
		logic        fixed_result;
		logic [15:0] want_l;
		logic [15:0] want_r;
	} step_row_t;

	typedef struct packed {
		logic [15:0] l;
		logic [15:0] r;
	} frame_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                  wr_en;
	cfg_idx_t              wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	tom_in_if  #(.SAMPLE_WIDTH(SW)) samples_ch ();
	tom_out_if #(.SAMPLE_WIDTH(SW)) mixed_ch ();

	tanh_overdrive_tone_mix #(
		.TANH_SEGMENTS(TANH_SEGS),
		.SAMPLE_WIDTH (SW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.samples (samples_ch),
		.mixed   (mixed_ch)
	);

	always #10 clk = ~clk;

	longint unsigned tanh_points [TANH_SEGS+1];
	logic [15:0] drive_q = DRIVE_RESET;
	logic [14:0] norm_q  = NORM_RESET;
	logic [15:0] tone_q  = TONE_RESET;
	logic [16:0] wet_q   = WET_RESET;
	logic [16:0] dry_q   = DRY_RESET;
	longint      lp_left_st  = 0;
	longint      lp_right_st = 0;

	frame_t mix_due [$];
	int     error_count  = 0;
	bit     gaps_on      = 1'b1;
	bit     hold_off_req = 1'b0;

	initial begin : tanh_points_init
		longint          series;
		longint unsigned term, ratio, e, num, den;
		series = 0;
		term   = 64'd1 << 32;
		for (int n = 0; n < 24; n++) begin
			if (n % 2 == 1) series -= longint'(term);
			else series += longint'(term);
			term = (term * 8) / (64'(TANH_SEGS) * 64'(n + 1));
		end
		if (series < 0) series = 0;
		ratio = series;
		if (ratio >= (64'd1 << 32)) ratio = (64'd1 << 32) - 1;
		e = 64'd1 << 32;
		for (int k = 0; k <= TANH_SEGS; k++) begin
			num = ((64'd1 << 32) - e) << 16;
			den = (64'd1 << 32) + e;
			tanh_points[k] = (num + den / 2) / den;
			e = (e * ratio + (64'd1 << 31)) >> 32;
		end
	end

	function automatic logic [SW-1:0] overdrive_channel(input logic signed [SW-1:0] x,
			inout longint lp);
		longint          xs, shaped, acc;
		longint unsigned mag, pos, seg, frac, th, lo_pt, hi_pt, step, scaled;
		xs   = x;
		mag  = (xs < 0) ? -xs : xs;
		pos  = mag * drive_q * TANH_SEGS;
		seg  = pos >> FRAC_BITS;
		frac = pos & ((64'd1 << FRAC_BITS) - 1);
		if (seg >= TANH_SEGS) begin
			th = TANH_ONE;
		end else begin
			lo_pt = tanh_points[seg];
			hi_pt = tanh_points[seg + 1];
			step  = (hi_pt >= lo_pt) ? hi_pt - lo_pt : 0;
			th    = lo_pt + ((step * frac + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		end
		scaled = (th * norm_q + 8192) >> 14;
		shaped = longint'(scaled << 6);
		if (xs < 0) shaped = -shaped;
		if (shaped > LP_HI) shaped = LP_HI;
		if (shaped < LP_LO) shaped = LP_LO;
		lp = lp + ((longint'(tone_q) * (shaped - lp) + (longint'(1) << 15)) >>> 16);
		if (lp > LP_HI) lp = LP_HI;
		if (lp < LP_LO) lp = LP_LO;
		acc = longint'(dry_q) * xs * 256 + longint'(wet_q) * lp;
		acc = (acc + (longint'(1) << 22)) >>> 23;
		if (acc > OUT_HI) acc = OUT_HI;
		if (acc < OUT_LO) acc = OUT_LO;
		return acc[SW-1:0];
	endfunction

	function automatic void apply_register(input cfg_idx_t ix, input logic [16:0] val);
		case (ix)
			REG_DRIVE_GAIN: drive_q = val[15:0];
			REG_NORM_GAIN:  norm_q  = val[14:0];
			REG_TONE_COEF:  tone_q  = val[15:0];
			REG_WET_GAIN:   wet_q   = val;
			REG_DRY_GAIN:   dry_q   = val;
			default: ;
		endcase
	endfunction

	function automatic step_row_t write_row(input cfg_idx_t ix, input int val);
		step_row_t row;
		row      = '0;
		row.kind = ROW_WRITE;
		row.ix   = ix;
		row.val  = 17'(val);
		return row;
	endfunction

	function automatic step_row_t frame_row(input int l, input int r);
		step_row_t row;
		row      = '0;
		row.kind = ROW_FRAME;
		row.l    = 16'(l);
		row.r    = 16'(r);
		return row;
	endfunction

	function automatic step_row_t checked_row(input int l, input int r, input int wl,
			input int wr);
		step_row_t row;
		row              = frame_row(l, r);
		row.fixed_result = 1'b1;
		row.want_l       = 16'(wl);
		row.want_r       = 16'(wr);
		return row;
	endfunction

	// zero row ends the table
	function automatic step_row_t plan_row(input int i);
		case (i)
			0:  return checked_row(0, 0, 0, 0);
			1:  return frame_row(32767, -32768);
			2:  return frame_row(-32768, 32767);
			3:  return frame_row(1, -1);
			4:  return frame_row(16'h5555, -21846);
			5:  return frame_row(-1, 1);
			6:  return write_row(REG_SPARE_5, 17'h1FFFF);
			7:  return write_row(REG_SPARE_6, 0);
			8:  return write_row(REG_SPARE_7, 17'h15555);
			9:  return frame_row(12345, -12345);
			10: return write_row(REG_DRIVE_GAIN, 51200);
			11: return write_row(REG_NORM_GAIN, 32767);
			12: return write_row(REG_TONE_COEF, 65535);
			13: return write_row(REG_WET_GAIN, 0);
			14: return write_row(REG_DRY_GAIN, 65536);
			15: return checked_row(32767, -32768, 32767, -32768);
			16: return checked_row(100, -100, 200, -200);
			17: return checked_row(8192, -8192, 16384, -16384);
			18: return checked_row(0, 0, 0, 0);
			19: return write_row(REG_DRIVE_GAIN, 1024);
			20: return write_row(REG_NORM_GAIN, 16384);
			21: return write_row(REG_TONE_COEF, 0);
			22: return write_row(REG_WET_GAIN, 65536);
			23: return write_row(REG_DRY_GAIN, 0);
			24: return frame_row(32767, -32768);
			25: return frame_row(-20000, 20000);
			26: return write_row(REG_TONE_COEF, 65535);
			27: return frame_row(32767, -32768);
			28: return frame_row(-32768, 32767);
			29: return frame_row(0, 0);
			30: return write_row(REG_DRIVE_GAIN, 0);
			31: return write_row(REG_NORM_GAIN, 0);
			32: return write_row(REG_TONE_COEF, 1);
			33: return write_row(REG_WET_GAIN, 131071);
			34: return write_row(REG_DRY_GAIN, 131071);
			35: return frame_row(32767, -32768);
			36: return frame_row(-32768, 32767);
			37: return write_row(REG_DRIVE_GAIN, 65535);
			38: return write_row(REG_NORM_GAIN, 32767);
			39: return write_row(REG_TONE_COEF, 65535);
			40: return write_row(REG_WET_GAIN, 65536);
			41: return write_row(REG_DRY_GAIN, 65536);
			42: return frame_row(32767, -32768);
			43: return frame_row(256, -256);
			44: return frame_row(-1, 0);
			default: return '0;
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16'h7FFF;
					1: v = 16'h8000;
					2: v = 16'h0000;
					3: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			1, 2: begin
				v = 16'($urandom_range(0, 2047));
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			default: v = 16'($urandom_range(0, 16'hFFFF));
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < 40) $display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic write_reg(input cfg_idx_t ix, input logic [16:0] val);
		wr_en    <= 1'b1;
		wr_index <= ix;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		apply_register(ix, val);
		@(posedge clk);
	endtask

	task automatic offer_frame(input logic [15:0] l, input logic [15:0] r,
			input logic fixed_result, input logic [15:0] want_l, input logic [15:0] want_r);
		frame_t due;
		samples_ch.valid        <= 1'b1;
		samples_ch.sample_left  <= l;
		samples_ch.sample_right <= r;
		do @(posedge clk); while (samples_ch.ready !== 1'b1);
		due.l = overdrive_channel(l, lp_left_st);
		due.r = overdrive_channel(r, lp_right_st);
		if (fixed_result) begin
			due.l = want_l;
			due.r = want_r;
		end
		mix_due.push_back(due);
	endtask

	task automatic idle_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// drop valid and wait until every word has come back
	task automatic settle();
		samples_ch.valid <= 1'b0;
		while (mix_due.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_words
		frame_t due;
		if (arst_n && mixed_ch.valid === 1'b1 && mixed_ch.ready === 1'b1) begin
			if (mix_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word L=%0d R=%0d",
					mixed_ch.out_left, mixed_ch.out_right));
			end else begin
				due = mix_due.pop_front();
				if (mixed_ch.out_left !== due.l)
					report_mismatch($sformatf("out_left %0d, want %0d",
						mixed_ch.out_left, $signed(due.l)));
				if (mixed_ch.out_right !== due.r)
					report_mismatch($sformatf("out_right %0d, want %0d",
						mixed_ch.out_right, $signed(due.r)));
			end
		end
	end

	initial begin : sink_side
		int n;
		mixed_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				mixed_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				mixed_ch.ready <= 1'b0;
				n = $urandom_range(1, 15);
				repeat (n) @(posedge clk);
			end
			mixed_ch.ready <= 1'b1;
			n = $urandom_range(1, 30);
			repeat (n) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1) ||
					(mixed_ch.valid === 1'b1 && mixed_ch.ready === 1'b1) || wr_en === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		step_row_t   row;
		int          i;
		logic [16:0] lo, hi, val;
		samples_ch.valid        <= 1'b0;
		samples_ch.sample_left  <= '0;
		samples_ch.sample_right <= '0;
		wr_en    <= 1'b0;
		wr_index <= REG_DRIVE_GAIN;
		wr_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		i   = 0;
		row = plan_row(i);
		while (row.kind != ROW_END) begin
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.ix, row.val);
			end else begin
				offer_frame(row.l, row.r, row.fixed_result, row.want_l, row.want_r);
				idle_gap();
			end
			i++;
			row = plan_row(i);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			for (cfg_idx_t ix = REG_DRIVE_GAIN; ix <= REG_DRY_GAIN; ix++) begin
				case (ix)
					REG_DRIVE_GAIN: begin lo = 17'd1024;  hi = 17'd51200; end
					REG_NORM_GAIN:  begin lo = 17'd16384; hi = 17'd32767; end
					REG_TONE_COEF:  begin lo = 17'd0;     hi = 17'd65535; end
					default:        begin lo = 17'd0;     hi = 17'd65536; end
				endcase
				case ($urandom_range(0, 5))
					0: val = lo;
					1: val = hi;
					2: val = 17'($urandom_range(0, 17'h1FFFF));
					default: val = 17'($urandom_range(lo, hi));
				endcase
				write_reg(ix, val);
			end
			if ($urandom_range(0, 1) == 1)
				write_reg(cfg_idx_t'($urandom_range(REG_SPARE_5, REG_SPARE_7)),
					17'($urandom_range(0, 17'h1FFFF)));
			gaps_on      = (ph != RANDOM_PHASES - 1);
			hold_off_req = (ph == 1);
			repeat (FRAMES_PER_PHASE) begin
				offer_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
				idle_gap();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
